### rtl/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/fpsp_pkg.sv
package fpsp_pkg;

  typedef logic signed [31:0] angle_t;
  typedef logic signed [17:0] sine_t;
  // reduced argument, quarter turn at most, in 16-bit turns
  typedef logic signed [15:0] frac_t;
  // squared argument, at most 4096
  typedef logic [12:0] sq_t;
  typedef logic signed [24:0] acc_t;

  // 2*pi in 16.16 and its scaled reciprocal floor(2^48 / TWO_PI)
  localparam logic [18:0] TWO_PI = 19'd411775;
  localparam longint unsigned RECIP_FULL = (64'd1 << 48) / 64'd411775;
  localparam logic [29:0] RECIP = RECIP_FULL[29:0];

  localparam logic [15:0] THREE_QUARTER = 16'd49152;
  localparam logic [15:0] ONE_QUARTER   = 16'd16384;
  localparam logic [15:0] HALF_TURN     = 16'd32768;

  localparam int HORNER_TERMS = 4;
  localparam acc_t HORNER_LEAD = 25'sd2602479;
  localparam acc_t HORNER_TAIL [HORNER_TERMS] = '{
    -25'sd5018418, 25'sd5347884, -25'sd2709368, 25'sd411775
  };

  localparam int REDUCE_STAGES = 5;
  localparam int HORNER_STAGES = HORNER_TERMS + 1;

endpackage

### rtl/fpsp_reduce.sv
`include "assert_macros.svh"

module fpsp_reduce import fpsp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  angle_t angle,
  output logic   out_valid,
  input  logic   out_ready,
  output frac_t  x
);

  localparam int STAGES = REDUCE_STAGES;

  logic [STAGES-1:0] valid;
  logic [STAGES:0]   en;

  logic        neg1, neg2, neg3;
  logic [31:0] mag1;
  logic [4:0]  low2;
  logic [29:0] quo2;
  logic [20:0] rem3;
  logic [15:0] quo_lo3;
  logic [15:0] rev4;

  logic [61:0] prod_c;
  logic [39:0] back_c;
  logic [15:0] q16_c;
  frac_t       fold_c;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign prod_c = 62'(mag1) * 62'(RECIP);
  assign back_c = 40'(quo2[20:0]) * 40'(TWO_PI);
  assign q16_c  = quo_lo3 + 16'(rem3 >= 21'(TWO_PI));

  always_comb begin
    priority if (rev4 > THREE_QUARTER) begin
      fold_c = frac_t'(rev4);
    end else if (rev4 > ONE_QUARTER) begin
      fold_c = frac_t'(HALF_TURN - rev4);
    end else begin
      fold_c = frac_t'(rev4);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg1 <= angle[31];
      mag1 <= angle[31] ? (~angle + 32'd1) : angle;
    end
    if (en[1]) begin
      neg2 <= neg1;
      low2 <= mag1[4:0];
      quo2 <= prod_c[61:32];
    end
    if (en[2]) begin
      neg3    <= neg2;
      quo_lo3 <= quo2[15:0];
      rem3    <= {low2, 16'd0} - back_c[20:0];
    end
    if (en[3]) begin
      rev4 <= neg3 ? (~q16_c + 16'd1) : q16_c;
    end
    if (en[4]) begin
      x <= fold_c;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];

  `ASSERT_IMPLIES(a_fold_range, clk, rst, out_valid, (x >= -16'sd16384) && (x <= 16'sd16384), "reduced argument outside a quarter turn")
  `ASSERT_IMPLIES(a_rem_range, clk, rst, valid[2], rem3 < 21'(2 * 411775), "division remainder out of range")

endmodule

### rtl/fpsp_horner.sv
`include "assert_macros.svh"

module fpsp_horner import fpsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  frac_t x_in,
  output logic  out_valid,
  input  logic  out_ready,
  output frac_t x_out,
  output acc_t  acc_out
);

  localparam int STAGES = HORNER_STAGES;

  logic [STAGES-1:0] valid;
  logic [STAGES:0]   en;

  sq_t   sq_q  [STAGES];
  frac_t x_q   [STAGES];
  acc_t  acc_q [STAGES];

  logic signed [31:0] sqp_c;
  logic signed [38:0] prod_c [1:STAGES-1];

  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign sqp_c = x_in * x_in;

  always_comb begin
    for (int k = 1; k < STAGES; k++) begin
      prod_c[k] = $signed({1'b0, sq_q[k-1]}) * acc_q[k-1];
    end
  end

  // square in the first stage, then one Horner step per stage; the arithmetic shift floors
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_q[0]  <= sqp_c[28:16];
      x_q[0]   <= x_in;
      acc_q[0] <= HORNER_LEAD;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        sq_q[k]  <= sq_q[k-1];
        x_q[k]   <= x_q[k-1];
        acc_q[k] <= HORNER_TAIL[k-1] + acc_t'(prod_c[k] >>> 16);
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];
  assign x_out     = x_q[STAGES-1];
  assign acc_out   = acc_q[STAGES-1];

  `ASSERT_IMPLIES(a_square_range, clk, rst, valid[0], sq_q[0] <= 13'd4096, "squared argument above one sixteenth")

endmodule

### rtl/fixed_point_sine_polynomial.sv
// Fixed-point sine: signed 16.16 radians in, signed 2.16 sine out.
// Throughput: one word per cycle unless the output stalls; the 11 register
// stages advance independently, so bubbles close up and a stall at the output
// holds only the full stages.
// Reset (rst, synchronous, active high) clears every stage valid bit; data stays.
`include "assert_macros.svh"

module fixed_point_sine_polynomial import fpsp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  angle_t angle,
  output logic   out_valid,
  input  logic   out_ready,
  output sine_t  sine
);

  // stages: range reduction, then square and Horner, then the output product
  localparam int PIPE_DEPTH = REDUCE_STAGES + HORNER_STAGES + 1;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  // reduced argument between range reduction and polynomial
  logic  r_valid;
  logic  r_ready;
  frac_t r_x;

  // argument and polynomial sum ready for the last multiply
  logic  h_valid;
  logic  h_ready;
  frac_t h_x;
  acc_t  h_acc;

  logic               out_en;
  logic signed [40:0] prod_c;
  sine_t              sine_next;
  logic [CNT_W-1:0]   in_flight;

  // Angle to revolutions by reciprocal multiply with one correction step,
  // keep the fractional turn and fold it into a quarter turn.
  fpsp_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .angle     (angle),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .x         (r_x)
  );

  // Square the argument, then run the four Horner steps, one per stage.
  fpsp_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .x_in      (r_x),
    .out_valid (h_valid),
    .out_ready (h_ready),
    .x_out     (h_x),
    .acc_out   (h_acc)
  );

  // Final stage: scale the sum by the argument, floor the 16.16 product and
  // keep the low 18 bits. Advance whenever the output word is empty or taken.
  assign out_en    = !out_valid || out_ready;
  assign h_ready   = out_en;
  assign prod_c    = h_x * h_acc;
  assign sine_next = sine_t'(prod_c >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      sine <= sine_next;
    end
  end

  // Words accepted but not yet delivered; never more than the stage count.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      unique case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   in_flight <= in_flight + CNT_W'(1);
        2'b01:   in_flight <= in_flight - CNT_W'(1);
        default: in_flight <= in_flight;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_in_flight_bound, clk, rst, in_flight <= CNT_W'(PIPE_DEPTH), "more words in flight than stages")
  `ASSERT_IMPLIES(a_block_only_full, clk, rst, !in_ready, out_valid && !out_ready && (in_flight == CNT_W'(PIPE_DEPTH)), "input held back while the pipeline has room")
  `ASSERT_IMPLIES(a_valid_has_word, clk, rst, out_valid, in_flight != '0, "result word with nothing in flight")

endmodule
